/* src/urlsph_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urlsph_pkg
// Shared widths, constants and the byte mix step for the scheme prefix hash.
// ----------------------------------------------------------------------------
package urlsph_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned HashW  = 32;
  localparam int unsigned PrefW  = 16;
  localparam int unsigned ValueW = HashW + PrefW;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [HashW-1:0]  hash_t;
  typedef logic [ValueW-1:0] value_t;

  localparam hash_t GoldenMult = 32'h9E37_79B9;
  localparam byte_t ColonCode  = 8'h3A;
  localparam int unsigned RotAmt = 5;

  // h' = GoldenMult * (rotl5(h) ^ b), mod 2^32
  function automatic hash_t mix_byte(hash_t h, byte_t b);
    hash_t rot;
    hash_t x;
    rot = {h[HashW-RotAmt-1:0], h[HashW-1:HashW-RotAmt]};
    x   = rot ^ {{(HashW-ByteW){1'b0}}, b};
    return x * GoldenMult;
  endfunction

endpackage

/* src/urlsph_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urlsph_if
// Valid/ready channels for string bytes in and hash results out.
// ----------------------------------------------------------------------------
interface urlsph_in_if;
  logic                 valid;
  logic                 ready;
  urlsph_pkg::byte_t    data_byte;
  logic                 last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface urlsph_out_if;
  logic                 valid;
  logic                 ready;
  urlsph_pkg::value_t   hash_value;
  logic                 no_colon;

  modport source (output valid, output hash_value, output no_colon, input ready);
  modport sink   (input valid, input hash_value, input no_colon, output ready);
endinterface

/* src/url_scheme_prefix_hash_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_scheme_prefix_hash_core
// Running full-string and scheme-prefix hashes over a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one string byte per transfer, last_byte marks the final byte.
//   out_ch : one result per string, issued for the last byte only.
//            hash_value = {prefix_hash[15:0], full_hash} when a colon was
//            seen, else 0 with no_colon set.
// Throughput: one byte per cycle unless a last byte waits on a stalled
//   result. The hash recurrence (rotate, xor, one constant 32x32 multiply
//   per hash) closes on itself each cycle and sets the clock period.
// Path: a last byte goes from the input register into the result register
//   once that register is free, and the result is offered on out_ch from
//   the result register.
// Stall: the result register holds while out_ch.ready is low. Bytes that
//   are not last keep flowing; a last byte waits in the input register
//   until the result register frees, and in_ch.ready drops behind it.
// Reset: synchronous, active low. Both hashes and the colon flag clear, and
//   both stages empty. State also returns to reset after each last byte.
// ----------------------------------------------------------------------------
module url_scheme_prefix_hash_core (
  input  logic          clk,
  input  logic          rst_n,
  urlsph_in_if.sink     in_ch,
  urlsph_out_if.source  out_ch
);

  // input register
  logic                a_valid_r;
  urlsph_pkg::byte_t   a_byte_r;
  logic                a_last_r;

  // hash state
  urlsph_pkg::hash_t   full_r,   full_nxt;
  urlsph_pkg::hash_t   prefix_r, prefix_nxt;
  logic                colon_r,  colon_nxt;

  // result register
  logic                out_valid_r;
  urlsph_pkg::value_t  out_value_r;
  logic                out_nc_r;

  logic                out_free;
  logic                a_adv;
  logic                is_colon;
  urlsph_pkg::hash_t   full_mix;
  urlsph_pkg::hash_t   prefix_mix;

  assign out_free = !out_valid_r || out_ch.ready;
  // a non-last byte never needs the result slot
  assign a_adv    = a_valid_r && (!a_last_r || out_free);
  assign in_ch.ready = !a_valid_r || a_adv;

  assign is_colon   = (a_byte_r == urlsph_pkg::ColonCode);
  assign full_mix   = urlsph_pkg::mix_byte(full_r, a_byte_r);
  assign prefix_mix = urlsph_pkg::mix_byte(prefix_r, a_byte_r);

  // post-step state; the prefix freezes at the first colon
  always_comb begin
    full_nxt   = full_mix;
    prefix_nxt = prefix_r;
    colon_nxt  = colon_r;
    if (!colon_r) begin
      if (is_colon) begin
        colon_nxt = 1'b1;
      end else begin
        prefix_nxt = prefix_mix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      full_r      <= '0;
      prefix_r    <= '0;
      colon_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        a_valid_r <= in_ch.valid;
      end

      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (a_adv) begin
        if (a_last_r) begin
          full_r      <= '0;
          prefix_r    <= '0;
          colon_r     <= 1'b0;
          out_valid_r <= 1'b1;
        end else begin
          full_r   <= full_nxt;
          prefix_r <= prefix_nxt;
          colon_r  <= colon_nxt;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      a_byte_r <= in_ch.data_byte;
      a_last_r <= in_ch.last_byte;
    end
    if (a_adv && a_last_r) begin
      if (colon_nxt) begin
        out_value_r <= {prefix_nxt[urlsph_pkg::PrefW-1:0], full_nxt};
        out_nc_r    <= 1'b0;
      end else begin
        out_value_r <= '0;
        out_nc_r    <= 1'b1;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = out_value_r;
  assign out_ch.no_colon   = out_nc_r;

  // state is back at reset after a string ends
  a_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && a_last_r) |=> (full_r == '0 && prefix_r == '0 && !colon_r))
    else $error("hash state not cleared after last byte");

  // input only backs up behind a last byte facing a stalled result
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (a_valid_r && a_last_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without cause");

  // once the colon is seen the prefix hash is frozen until string end
  a_prefix_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (colon_r && !(a_adv && a_last_r)) |=> $stable(prefix_r))
    else $error("prefix hash moved after colon");

  // a no-colon result carries a zero value
  a_nc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_nc_r) |-> (out_value_r == '0))
    else $error("no_colon result with nonzero value");

endmodule
